// File: src/button_press_classifier_assert.svh
// Assertion helpers shared by the checker.
`ifndef BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define BPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define BPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/bpc_pkg.sv
package bpc_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned EV_W      = 7;
  localparam int unsigned NUM_BTN   = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PURGE         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_MODE     = 2'd3;

  localparam logic [CFG_W-1:0] LONG_PRESS_RST    = 16'd1000;
  localparam logic [CFG_W-1:0] DOUBLE_WINDOW_RST = 16'd300;
  localparam logic [CFG_W-1:0] PURGE_RST         = 16'd1000;

  localparam int unsigned BTN_LEFT   = 0;
  localparam int unsigned BTN_CENTRE = 1;
  localparam int unsigned BTN_RIGHT  = 2;

  // pending event bits per button; centre has no long or double bit
  localparam logic [NUM_BTN-1:0][EV_W-1:0] SHORT_BIT = {7'h10, 7'h08, 7'h01};
  localparam logic [NUM_BTN-1:0][EV_W-1:0] LONG_BIT  = {7'h20, 7'h00, 7'h02};
  localparam logic [NUM_BTN-1:0][EV_W-1:0] DBL_BIT   = {7'h40, 7'h00, 7'h04};
  // bits that survive a purge tick (all but the short bits)
  localparam logic [EV_W-1:0] PURGE_KEEP = 7'h66;

  typedef struct packed {
    logic            left_level;
    logic            centre_level;
    logic            right_level;
    logic            flight_locked;
    logic [EV_W-1:0] ack_mask;
  } bpc_in_t;

  typedef struct packed {
    logic [EV_W-1:0] pending_events;
    logic            screen_reset;
    logic            beep_ok;
    logic            beep_double;
    logic            reboot_request;
    logic            hold_active;
  } bpc_out_t;

  // per-button outcome of one tick
  typedef struct packed {
    logic boot_short;
    logic long_hit;
    logic dbl_hit;
    logic late_short;
    logic hold;
  } bpc_btn_ev_t;

endpackage

// File: src/bpc_button.sv
module bpc_button import bpc_pkg::*; #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  purge_i,
  input  logic                  pressed_i,
  input  logic                  boot_i,
  input  logic [TIMER_BITS-1:0] thr_i,
  input  logic [TIMER_BITS-1:0] win_i,
  output bpc_btn_ev_t           ev_o
);

  localparam logic [TIMER_BITS-1:0] TMax = '1;

  logic [TIMER_BITS-1:0] pt_q, pt_d, sr_q, sr_d;
  logic [TIMER_BITS-1:0] sr_inc, pt_new;
  logic                  handled_q, handled_d;

  always_comb begin
    sr_inc    = (sr_q != TMax) ? sr_q + 1'b1 : sr_q;
    pt_new    = (pt_q != TMax) ? pt_q + 1'b1 : pt_q;
    pt_d      = pt_q;
    sr_d      = sr_inc;
    handled_d = handled_q;
    ev_o      = '0;
    if (purge_i) begin
      pt_d = '0;
    end else begin
      priority if (pressed_i && boot_i) begin
        ev_o.boot_short = 1'b1;
        handled_d       = 1'b1;
        pt_d            = '0;
      end else if (pressed_i) begin
        pt_d = pt_new;
        if (pt_q != TMax && pt_new == thr_i) begin
          ev_o.long_hit = 1'b1;
          handled_d     = 1'b1;
          sr_d          = '0;
        end
        ev_o.hold = (pt_new < thr_i);
      end else if (pt_q != '0) begin
        pt_d = '0;
        if (pt_q < thr_i) begin
          // saturated release timer never counts as inside the window
          if (sr_inc != TMax && sr_inc < win_i) begin
            ev_o.dbl_hit = 1'b1;
            handled_d    = 1'b1;
          end else begin
            handled_d = 1'b0;
          end
          sr_d = '0;
        end
      end else if (!handled_q && (sr_inc == TMax || sr_inc > win_i)) begin
        ev_o.late_short = 1'b1;
        handled_d       = 1'b1;
      end else begin
        pt_d = pt_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q      <= '0;
      sr_q      <= TMax;
      handled_q <= 1'b1;
    end else if (step_i) begin
      pt_q      <= pt_d;
      sr_q      <= sr_d;
      handled_q <= handled_d;
    end
  end

endmodule

// File: src/bpc_cfg_regs.sv
module bpc_cfg_regs import bpc_pkg::*; #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  output logic [TIMER_BITS-1:0] thr_o,
  output logic [TIMER_BITS-1:0] win_o,
  output logic [TIMER_BITS-1:0] purge_o,
  output logic                  boot_o
);

  // compare width wide enough for both the register and the timer
  localparam int unsigned CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [CW-1:0] TMaxExt = CW'({TIMER_BITS{1'b1}});

  logic [CFG_W-1:0] long_q, win_q, purge_q;
  logic             boot_q;
  logic [CW-1:0]    long_ext, win_ext, purge_ext;
  logic [TIMER_BITS-1:0] thr_clip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q  <= LONG_PRESS_RST;
      win_q   <= DOUBLE_WINDOW_RST;
      purge_q <= PURGE_RST;
      boot_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LONG_PRESS:    long_q  <= cfg_data_i;
        CFG_DOUBLE_WINDOW: win_q   <= cfg_data_i;
        CFG_PURGE:         purge_q <= cfg_data_i;
        CFG_BOOT_MODE:     boot_q  <= cfg_data_i[0];
        default:           boot_q  <= boot_q;
      endcase
    end
  end

  // clip to the timer range; a zero threshold acts as one
  always_comb begin
    long_ext  = CW'(long_q);
    win_ext   = CW'(win_q);
    purge_ext = CW'(purge_q);
    thr_clip  = (long_ext > TMaxExt) ? TMaxExt[TIMER_BITS-1:0] : long_ext[TIMER_BITS-1:0];
    thr_o     = (thr_clip == '0) ? TIMER_BITS'(1) : thr_clip;
    win_o     = (win_ext > TMaxExt) ? TMaxExt[TIMER_BITS-1:0] : win_ext[TIMER_BITS-1:0];
    purge_o   = (purge_ext > TMaxExt) ? TMaxExt[TIMER_BITS-1:0]
                                      : purge_ext[TIMER_BITS-1:0];
    boot_o    = boot_q;
  end

endmodule

// File: src/button_press_classifier.sv
// Button press classifier. One input beat is one 1 ms tick carrying three
// active-low button levels (left, centre, right), the flight-lock flag and an
// acknowledge mask for pending events. Each tick yields exactly one result
// beat: the pending event bits after this tick, plus one-tick pulses for
// screen reset, ok beep, double beep and reboot request, and a hold flag.
// Rate: one beat per clock. The whole tick update is one pass of logic from
// the held state and the incoming beat into the state registers and the
// result register, so the block accepts a beat every cycle; the only pause
// comes from the result register when its beat is stalled downstream, and
// then in_stall_o follows out_stall_i. out_valid_o is set in the cycle after
// an accept. A long press (long_press_ms ticks held) sets the long bit
// (centre: screen_reset) and starts a purge of purge_ms ticks, in which
// levels are ignored and short bits are cleared. Configuration writes are
// always taken (cfg_ready_o is tied high) and should only come while idle.
module button_press_classifier import bpc_pkg::*; #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input tick channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bpc_in_t              in_data_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bpc_out_t             out_data_o,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic [TIMER_BITS-1:0] thr, win, purge_len;
  logic                  boot;

  logic                  accept;
  logic [NUM_BTN-1:0]    pressed;
  bpc_btn_ev_t           ev [NUM_BTN];
  logic                  purge_act;

  logic [TIMER_BITS-1:0] purge_q, purge_d;
  logic [EV_W-1:0]       flags_q, flags_d;
  logic                  any_long;
  bpc_out_t              res;

  bpc_out_t              out_q;
  logic                  out_valid_q;

  assign cfg_ready_o = 1'b1;

  bpc_cfg_regs #(.TIMER_BITS(TIMER_BITS)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .thr_o       (thr),
    .win_o       (win),
    .purge_o     (purge_len),
    .boot_o      (boot)
  );

  // the result register frees up when its beat leaves or it is empty
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign purge_act  = (purge_q != '0);

  assign pressed[BTN_LEFT]   = ~in_data_i.left_level;
  assign pressed[BTN_CENTRE] = ~in_data_i.centre_level;
  assign pressed[BTN_RIGHT]  = ~in_data_i.right_level;

  for (genvar b = 0; b < NUM_BTN; b++) begin : g_btn
    bpc_button #(.TIMER_BITS(TIMER_BITS)) u_btn (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .step_i    (accept),
      .purge_i   (purge_act),
      .pressed_i (pressed[b]),
      .boot_i    (boot),
      .thr_i     (thr),
      .win_i     (win),
      .ev_o      (ev[b])
    );
  end

  // merge per-button outcomes into the event flags and pulses
  always_comb begin
    flags_d  = flags_q & ~in_data_i.ack_mask;
    any_long = 1'b0;
    res      = '0;
    if (purge_act) begin
      flags_d = flags_d & PURGE_KEEP;
    end else begin
      res.reboot_request = pressed[BTN_LEFT] & ~pressed[BTN_CENTRE] &
                           pressed[BTN_RIGHT] & ~in_data_i.flight_locked;
      for (int i = 0; i < NUM_BTN; i++) begin
        // a late short replaces any long or double still pending
        if (ev[i].late_short) begin
          flags_d = (flags_d & ~(LONG_BIT[i] | DBL_BIT[i])) | SHORT_BIT[i];
        end
        if (ev[i].boot_short) flags_d = flags_d | SHORT_BIT[i];
        if (ev[i].long_hit)   flags_d = flags_d | LONG_BIT[i];
        if (ev[i].dbl_hit)    flags_d = flags_d | DBL_BIT[i];
        any_long        = any_long | ev[i].long_hit;
        res.beep_ok     = res.beep_ok | ev[i].boot_short | ev[i].long_hit |
                          ev[i].late_short;
        res.beep_double = res.beep_double | ev[i].dbl_hit;
        res.hold_active = res.hold_active | ev[i].hold;
      end
      res.screen_reset = ev[BTN_CENTRE].long_hit | ev[BTN_CENTRE].dbl_hit;
    end
    res.pending_events = flags_d;

    if (purge_act)     purge_d = purge_q - 1'b1;
    else if (any_long) purge_d = purge_len;
    else               purge_d = purge_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      purge_q <= '0;
    end else if (accept) begin
      flags_q <= flags_d;
      purge_q <= purge_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= accept | in_stall_o;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: src/bpc_checker.sv
`include "button_press_classifier_assert.svh"

module bpc_checker import bpc_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input bpc_in_t              in_data_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input bpc_out_t             out_data_o,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o,
  input logic [CFG_IDX_W-1:0] cfg_index_i,
  input logic [CFG_W-1:0]     cfg_data_i
);

  logic in_acc;
  assign in_acc = in_valid_i & ~in_stall_o;

  // stalled result beat holds
  `BPC_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result beat changed")
  // every accepted tick shows a result next cycle
  `BPC_ASSERT_NXT(a_one_result, in_acc, out_valid_o, "accepted tick gave no result")
  // no new tick while the result register is blocked
  `BPC_ASSERT_IMP(a_no_overrun, out_valid_o && out_stall_i, in_stall_o, "input taken over blocked result")
  // flight lock suppresses reboot
  `BPC_ASSERT_NXT(a_lock_reboot, in_acc && in_data_i.flight_locked, !out_data_o.reboot_request, "reboot while locked")

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (.*);

// File: dv/button_press_classifier_checker.sv
module button_press_classifier_checker import bpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_o,
  input  bpc_in_t              in_data_i,
  input  logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  bpc_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   pending_o,
  output int                   fail_count_o
);

  localparam int unsigned    TIMER_BITS = 16;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  // shadow registers
  logic [CFG_W-1:0] long_ms;
  logic [CFG_W-1:0] window_ms;
  logic [CFG_W-1:0] purge_len;
  logic             boot_on;

  // shadow per-button timing state
  logic [TIMER_BITS-1:0] hold_ticks  [NUM_BTN];
  logic [TIMER_BITS-1:0] release_age [NUM_BTN];
  logic                  press_done  [NUM_BTN];
  logic [EV_W-1:0]       pending_ev;
  logic [TIMER_BITS-1:0] purge_count;

  bpc_out_t expected_ticks [$];
  bpc_out_t want;
  int       mismatch_count = 0;

  assign fail_count_o = mismatch_count;

  // One 1 ms tick of the classifier; updates the shadow state.
  function automatic bpc_out_t classify_tick(input bpc_in_t t);
    bpc_out_t              r;
    logic [NUM_BTN-1:0]    down;
    logic [TIMER_BITS-1:0] thr;
    logic [TIMER_BITS-1:0] win;
    r    = '0;
    thr  = (long_ms == '0) ? TIMER_BITS'(1) : long_ms;
    win  = window_ms;
    down = {~t.right_level, ~t.centre_level, ~t.left_level};

    // ack comes before any new event of this tick
    pending_ev = pending_ev & ~t.ack_mask;
    for (int i = 0; i < NUM_BTN; i++) begin
      if (release_age[i] != TIMER_MAX) release_age[i]++;
    end

    if (purge_count != '0) begin
      purge_count--;
      pending_ev = pending_ev & PURGE_KEEP;
      for (int i = 0; i < NUM_BTN; i++) hold_ticks[i] = '0;
    end else begin
      r.reboot_request = down[BTN_LEFT] && !down[BTN_CENTRE] && down[BTN_RIGHT] &&
                         !t.flight_locked;
      for (int i = 0; i < NUM_BTN; i++) begin
        if (down[i] && boot_on) begin
          pending_ev    |= SHORT_BIT[i];
          r.beep_ok      = 1'b1;
          press_done[i]  = 1'b1;
          hold_ticks[i]  = '0;
        end else if (down[i]) begin
          if (hold_ticks[i] != TIMER_MAX) begin
            hold_ticks[i]++;
            if (hold_ticks[i] == thr) begin
              if (i == BTN_CENTRE) r.screen_reset = 1'b1;
              else pending_ev |= LONG_BIT[i];
              purge_count    = purge_len;
              r.beep_ok      = 1'b1;
              press_done[i]  = 1'b1;
              release_age[i] = '0;
            end
          end
          if (hold_ticks[i] < thr) r.hold_active = 1'b1;
        end else if (hold_ticks[i] != '0) begin
          if (hold_ticks[i] < thr) begin
            if (release_age[i] != TIMER_MAX && release_age[i] < win) begin
              if (i == BTN_CENTRE) r.screen_reset = 1'b1;
              else pending_ev |= DBL_BIT[i];
              r.beep_double = 1'b1;
              press_done[i] = 1'b1;
            end else begin
              press_done[i] = 1'b0;
            end
            release_age[i] = '0;
          end
          hold_ticks[i] = '0;
        end else if (!press_done[i] &&
                     (release_age[i] == TIMER_MAX || release_age[i] > win)) begin
          pending_ev     = pending_ev & ~(LONG_BIT[i] | DBL_BIT[i]);
          pending_ev    |= SHORT_BIT[i];
          r.beep_ok      = 1'b1;
          press_done[i]  = 1'b1;
        end
      end
    end
    r.pending_events = pending_ev;
    return r;
  endfunction

  function automatic int field_bad(input string name, input logic [EV_W-1:0] exp_v,
                                   input logic [EV_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ms     = LONG_PRESS_RST;
      window_ms   = DOUBLE_WINDOW_RST;
      purge_len   = PURGE_RST;
      boot_on     = 1'b0;
      for (int i = 0; i < NUM_BTN; i++) begin
        hold_ticks[i]  = '0;
        release_age[i] = TIMER_MAX;
        press_done[i]  = 1'b1;
      end
      pending_ev  = '0;
      purge_count = '0;
      expected_ticks.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_LONG_PRESS:    long_ms   = cfg_data_i;
          CFG_DOUBLE_WINDOW: window_ms = cfg_data_i;
          CFG_PURGE:         purge_len = cfg_data_i;
          CFG_BOOT_MODE:     boot_on   = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_ticks.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %0h", $time, out_data_o);
          mismatch_count++;
        end else begin
          want = expected_ticks.pop_front();
          mismatch_count += field_bad("pending_events", want.pending_events,
                                      out_data_o.pending_events);
          mismatch_count += field_bad("screen_reset", EV_W'(want.screen_reset),
                                      EV_W'(out_data_o.screen_reset));
          mismatch_count += field_bad("beep_ok", EV_W'(want.beep_ok),
                                      EV_W'(out_data_o.beep_ok));
          mismatch_count += field_bad("beep_double", EV_W'(want.beep_double),
                                      EV_W'(out_data_o.beep_double));
          mismatch_count += field_bad("reboot_request", EV_W'(want.reboot_request),
                                      EV_W'(out_data_o.reboot_request));
          mismatch_count += field_bad("hold_active", EV_W'(want.hold_active),
                                      EV_W'(out_data_o.hold_active));
        end
      end
      if (in_valid_i && !in_stall_o) expected_ticks.push_back(classify_tick(in_data_i));
      pending_o <= expected_ticks.size();
    end
  end

endmodule

// File: dv/button_press_classifier_test.sv
module button_press_classifier_test;
  import bpc_pkg::*;

  // Run-away guard, far above the slowest legal run (~1.7k ticks, heavy stalls).
  localparam int CYCLE_LIMIT = 500000;
  localparam int RAND_TICKS  = 280;   // per register setting
  localparam int NUM_SETS    = 6;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  bpc_in_t              in_data_i   = '1;  // all buttons released
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  bpc_out_t             out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_LONG_PRESS;
  logic [CFG_W-1:0]     cfg_data_i  = '0;

  int pending;
  int fail_count;
  int cycle_count = 0;
  int ticks_sent  = 0;

  // idle percentages for the sender and the receiver
  int send_idle = 0;
  int recv_idle = 0;

  // current settings, used to shape gestures around the thresholds
  int cur_long  = int'(LONG_PRESS_RST);
  int cur_win   = int'(DOUBLE_WINDOW_RST);
  int cur_purge = int'(PURGE_RST);

  // per-button gesture generator: level and ticks left at that level
  bit btn_down [NUM_BTN];
  int run_len  [NUM_BTN];

  button_press_classifier DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  button_press_classifier_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver backpressure; redrawn every cycle.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99, 0) < recv_idle);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("FAIL button_press_classifier");
      $finish;
    end
  end

  // One tick beat: optional idle cycles first, then hold the beat until taken.
  // Valid is left high so back-to-back beats need no extra NBA on it.
  task automatic send_tick(input bpc_in_t t);
    while ($urandom_range(99, 0) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
    ticks_sent++;
  endtask

  // Wait until every expected result beat has come back. Always waits on a
  // clock edge before testing the count, so the checker's count of the last push is seen.
  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Writes all four registers back to back; valid stays high between beats.
  task automatic program_settings(input logic [CFG_W-1:0] lp, input logic [CFG_W-1:0] dw,
                                  input logic [CFG_W-1:0] pg, input logic bm);
    logic [CFG_IDX_W-1:0] idx  [4];
    logic [CFG_W-1:0]     vals [4];
    idx  = '{CFG_LONG_PRESS, CFG_DOUBLE_WINDOW, CFG_PURGE, CFG_BOOT_MODE};
    vals = '{lp, dw, pg, {{(CFG_W-1){1'b0}}, bm}};
    for (int k = 0; k < 4; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= vals[k];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    cur_long  = int'(lp);
    cur_win   = int'(dw);
    cur_purge = int'(pg);
  endtask

  initial begin
    // Directed opener, run with long=3, window=3, purge=2. Each entry is
    // {left, centre, right, flight_locked} levels (0 = pressed) and ack_mask.
    bpc_in_t opening_ticks [24];
    // register settings for the random phases: short thresholds mostly so
    // gestures finish quickly; minimum values, zero threshold/purge, boot
    // mode and the 16-bit maxima are all visited
    int set_long  [NUM_SETS];
    int set_win   [NUM_SETS];
    int set_purge [NUM_SETS];
    bit set_boot  [NUM_SETS];
    int thr_eff;
    int hi;
    int pick;
    bpc_in_t t;

    opening_ticks = '{
      {4'b1110, 7'h7F},  // idle, ack everything
      {4'b0110, 7'h00},  // left tap ...
      {4'b1110, 7'h00},  // ... released, waits out the window
      {4'b1110, 7'h00},
      {4'b1110, 7'h00},
      {4'b1110, 7'h00},
      {4'b1110, 7'h00},  // left short fires here
      {4'b1100, 7'h00},  // right tap
      {4'b1110, 7'h00},
      {4'b1100, 7'h00},  // second right tap inside the window
      {4'b1110, 7'h00},  // right double
      {4'b1111, 7'h7F},  // same-tick ack of everything, locked
      {4'b0100, 7'h00},  // left+right, centre up, unlocked: reboot
      {4'b0101, 7'h00},  // same but locked: no reboot
      {4'b0000, 7'h00},  // all held: left and right go long, purge starts
      {4'b0000, 7'h00},  // purge tick
      {4'b0000, 7'h00},  // purge tick
      {4'b0000, 7'h00},  // still held after purge: timing restarts
      {4'b1011, 7'h10},  // left and right up, centre held, partial ack
      {4'b1111, 7'h00},  // all up
      {4'b1111, 7'h00},
      {4'b1111, 7'h00},
      {4'b1111, 7'h00},
      {4'b1111, 7'h00}
    };
    set_long  = '{5, 1, 12, 8, 0, 65535};
    set_win   = '{4, 1, 20, 6, 65535, 3};
    set_purge = '{3, 0, 6, 4, 2, 65535};
    set_boot  = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle <= 21;
    recv_idle <= 87;
    program_settings(16'd3, 16'd3, 16'd2, 1'b0);
    foreach (opening_ticks[n]) send_tick(opening_ticks[n]);
    in_valid_i <= 1'b0;

    for (int s = 0; s < NUM_SETS; s++) begin
      wait_drained();
      program_settings(CFG_W'(set_long[s]), CFG_W'(set_win[s]), CFG_W'(set_purge[s]),
                       set_boot[s]);
      // idle mix: sender light/receiver heavy, then swapped, then full rate
      if (s < 2) begin
        send_idle <= 21;
        recv_idle <= 87;
      end else if (s < 4) begin
        send_idle <= 87;
        recv_idle <= 21;
      end else begin
        send_idle <= 0;
        recv_idle <= 0;
      end
      thr_eff = (cur_long == 0) ? 1 : cur_long;

      for (int n = 0; n < RAND_TICKS; n++) begin
        // Gestures: each button alternates press and release runs whose
        // lengths land just under, at or past the long threshold, and gaps
        // inside or outside the double window.
        for (int b = 0; b < NUM_BTN; b++) begin
          if (run_len[b] == 0) begin
            btn_down[b] = !btn_down[b];
            pick = $urandom_range(99, 0);
            if (btn_down[b]) begin
              hi = (thr_eff - 1 > 30) ? 30 : thr_eff - 1;
              if (hi < 1) hi = 1;
              if (pick < 55) run_len[b] = $urandom_range(hi, 1);
              else if (pick < 80 && thr_eff <= 40)
                run_len[b] = thr_eff + $urandom_range(((cur_purge > 8) ? 8 : cur_purge) + 3, 0);
              else if (pick < 80) run_len[b] = $urandom_range(40, 30);
              else run_len[b] = 1;
            end else begin
              hi = (cur_win > 30) ? 30 : cur_win;
              if (pick < 45) run_len[b] = $urandom_range(hi, 1);
              else if (pick < 85) run_len[b] = hi + $urandom_range(6, 1);
              else run_len[b] = $urandom_range(60, 20);
            end
          end
          run_len[b]--;
        end
        t.left_level    = !btn_down[BTN_LEFT];
        t.centre_level  = !btn_down[BTN_CENTRE];
        t.right_level   = !btn_down[BTN_RIGHT];
        t.flight_locked = 1'($urandom_range(1, 0));
        // some noise ticks with arbitrary levels
        if ($urandom_range(99, 0) < 10) begin
          {t.left_level, t.centre_level, t.right_level} = 3'($urandom_range(7, 0));
        end
        // acks are mostly absent so events pile up
        pick = $urandom_range(99, 0);
        if (pick < 75) t.ack_mask = '0;
        else if (pick < 90) t.ack_mask = EV_W'($urandom_range(127, 0));
        else t.ack_mask = 7'd1 << $urandom_range(EV_W - 1, 0);
        send_tick(t);
      end
      in_valid_i <= 1'b0;
    end

    wait_drained();
    // settle: the result is registered straight from the accepted tick, so these edges catch any stray beat
    repeat (4) @(posedge clk_i);

    $display("%0d ticks checked over %0d register settings (boot mode, zero and max values)",
             ticks_sent, NUM_SETS + 1);
    $display("with idle sender, idle receiver and full-rate traffic; %0d mismatches",
             fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS button_press_classifier");
    end else begin
      $display("FAIL button_press_classifier");
    end
    $finish;
  end

endmodule
